// File: hdl/pktu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pktu_pkg
// Shared types and constants for the peer key table.
// ----------------------------------------------------------------------------
package pktu_pkg;

   localparam int KEY_W    = 256;
   localparam int STAMP_W  = 32;
   localparam int SLOT_W   = 3;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 2'd3;

   localparam logic OP_CLEAR  = 1'b0;
   localparam logic OP_UPSERT = 1'b1;

   localparam logic [STAMP_W-1:0] STAMP_FIRST = 32'd1;
   localparam logic [STAMP_W-1:0] STAMP_LAST  = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_CMP,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      KIND_REFRESH,
      KIND_INSERT,
      KIND_REJECT,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      logic     load_req;
      logic     inc_idx;
      logic     act;
      kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic op_clear;
      logic used_zero;
      logic full;
      logic match;
      logic last;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// File: hdl/pktu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pktu_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pktu_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/pktu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pktu_datapath
// Key RAM, scan index, entry count, sequence counter and result register.
// ----------------------------------------------------------------------------
module pktu_datapath
   import pktu_pkg::*;
#(
   parameter int MAX_PEERS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   output dp_stat_type               stat,
   input  wire logic                 req_operation,
   input  wire logic [63:0]          req_key_word0,
   input  wire logic [63:0]          req_key_word1,
   input  wire logic [63:0]          req_key_word2,
   input  wire logic [63:0]          req_key_word3,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic [STAMP_W-1:0]        rsp_stamp,
   output logic [COUNT_W-1:0]        rsp_entry_count
);

   localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CNT_W = $clog2(MAX_PEERS + 1);

   logic                op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STAMP_W-1:0]  rsp_stamp_ff, rsp_stamp_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [KEY_W-1:0]    rd_key;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [CNT_W-1:0]    idx_inc;
   logic [CNT_W-1:0]    used_inc;
   logic [STAMP_W-1:0]  stamp_next;
   logic [IDX_W+SLOT_W-1:0]  idx_wide, wr_wide;
   logic [CNT_W+COUNT_W-1:0] used_wide, used_inc_wide;

   pktu_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_PEERS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_key)
   );

   assign idx_inc       = CNT_W'(idx_ff) + CNT_W'(1);
   assign used_inc      = used_ff + CNT_W'(1);
   assign wr_idx        = used_ff[IDX_W-1:0];
   assign stamp_next    = (stamp_ff == STAMP_LAST) ? STAMP_FIRST : stamp_ff + STAMP_W'(1);
   assign idx_wide      = {{SLOT_W{1'b0}}, idx_ff};
   assign wr_wide       = {{SLOT_W{1'b0}}, wr_idx};
   assign used_wide     = {{COUNT_W{1'b0}}, used_ff};
   assign used_inc_wide = {{COUNT_W{1'b0}}, used_inc};
   assign wr_en         = cmd.act && (cmd.kind == KIND_INSERT);

   always_comb begin
      stat.op_clear  = (op_ff == OP_CLEAR);
      stat.used_zero = (used_ff == '0);
      stat.full      = (used_ff == CNT_W'(MAX_PEERS));
      stat.match     = (rd_key == key_ff);
      stat.last      = (idx_inc == used_ff);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      idx_in        = idx_ff;
      used_in       = used_ff;
      stamp_in      = stamp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.load_req) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_inc[IDX_W-1:0];
      end
      if (cmd.act) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = '0;
         rsp_stamp_in = '0;
         rsp_count_in = used_wide[COUNT_W-1:0];
         case (cmd.kind)
            KIND_REFRESH: begin
               rsp_status_in = STATUS_REFRESHED;
               rsp_slot_in   = idx_wide[SLOT_W-1:0];
               rsp_stamp_in  = stamp_ff;
               stamp_in      = stamp_next;
            end
            KIND_INSERT: begin
               rsp_status_in = STATUS_INSERTED;
               rsp_slot_in   = wr_wide[SLOT_W-1:0];
               rsp_stamp_in  = stamp_ff;
               rsp_count_in  = used_inc_wide[COUNT_W-1:0];
               stamp_in      = stamp_next;
               used_in       = used_inc;
            end
            KIND_REJECT: begin
               rsp_status_in = STATUS_REJECTED;
            end
            KIND_CLEAR: begin
               rsp_status_in = STATUS_CLEARED;
               rsp_count_in  = '0;
               used_in       = '0;
               stamp_in      = STAMP_FIRST;
            end
            default: begin
               rsp_status_in = STATUS_REJECTED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         used_ff      <= '0;
         stamp_ff     <= STAMP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_operation;
         key_ff <= {req_key_word3, req_key_word2, req_key_word1, req_key_word0};
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_stamp       = rsp_stamp_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire

// File: hdl/pktu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pktu_ctrl
// Sequencer: takes a beat, scans used entries, then commits one outcome.
// ----------------------------------------------------------------------------
module pktu_ctrl
   import pktu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (stat.op_clear) begin
               kind_in  = KIND_CLEAR;
               state_in = ST_FINISH;
            end else if (stat.used_zero) begin
               kind_in  = stat.full ? KIND_REJECT : KIND_INSERT;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.match) begin
               kind_in  = KIND_REFRESH;
               state_in = ST_FINISH;
            end else if (stat.last) begin
               kind_in  = stat.full ? KIND_REJECT : KIND_INSERT;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      cmd.load_req = (state_ff == ST_IDLE) && req_valid;
      cmd.inc_idx  = (state_ff == ST_CMP) && !stat.match && !stat.last;
      cmd.act      = (state_ff == ST_FINISH) && stat.out_free;
      cmd.kind     = kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_CLEAR;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/peer_key_table_upsert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peer_key_table_upsert
// Table of up to MAX_PEERS 256-bit peer keys with a wrapping sequence stamp.
// ----------------------------------------------------------------------------
// One request beat yields exactly one response beat. A clear, or an upsert
// into an empty table, goes from START straight to FINISH, where its
// response is loaded. Any other upsert compares the used entries in order
// until a match or the last one, each in a READ state and then a CMP state,
// as the key RAM has one registered read port. A new request is taken in the
// cycle after the response is loaded, even while that response is still
// stalled. The load waits while the previous response beat is still stalled.
// The key RAM needs no clearing pass: only used entries are ever read.
// Sequence stamps start at 1 after reset or clear and skip 0 on wrap.
// ----------------------------------------------------------------------------
module peer_key_table_upsert
   import pktu_pkg::*;
#(
   parameter int MAX_PEERS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_operation,
   input  wire logic [63:0]         req_key_word0,
   input  wire logic [63:0]         req_key_word1,
   input  wire logic [63:0]         req_key_word2,
   input  wire logic [63:0]         req_key_word3,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [STAMP_W-1:0]       rsp_stamp,
   output logic [COUNT_W-1:0]       rsp_entry_count
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pktu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pktu_datapath #(
      .MAX_PEERS (MAX_PEERS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_key_word0   (req_key_word0),
      .req_key_word1   (req_key_word1),
      .req_key_word2   (req_key_word2),
      .req_key_word3   (req_key_word3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_stamp       (rsp_stamp),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
`default_nettype wire

// File: hdl/pktu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pktu_checker
// Port-level checks on the peer key table response channel.
// ----------------------------------------------------------------------------
module pktu_checker
   import pktu_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [SLOT_W-1:0]   rsp_slot,
   input wire logic [STAMP_W-1:0]  rsp_stamp,
   input wire logic [COUNT_W-1:0]  rsp_entry_count
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_stamp) && $stable(rsp_entry_count))
      else $error("stalled response beat changed");

   a_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CLEARED
         |-> rsp_entry_count == '0 && rsp_slot == '0 && rsp_stamp == '0)
      else $error("clear beat carries nonzero fields");

   a_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_REJECTED |-> rsp_slot == '0 && rsp_stamp == '0)
      else $error("reject beat carries slot or stamp");

   a_stamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REFRESHED || rsp_status == STATUS_INSERTED)
         |-> rsp_stamp != '0 && rsp_entry_count != '0)
      else $error("stamped beat has zero stamp or empty table");

endmodule

bind peer_key_table_upsert pktu_checker u_pktu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_slot        (rsp_slot),
   .rsp_stamp       (rsp_stamp),
   .rsp_entry_count (rsp_entry_count)
);
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the peer key table.
// ----------------------------------------------------------------------------
// A short table of directed requests first fills the table and runs it past
// full. It also covers refreshes, keys that differ from a stored key in one
// bit of one word, clears and refill after a clear. Random traffic follows,
// drawn mostly from a small pool of keys so that refreshes, inserts and
// rejects mix, with near-miss keys, fresh keys and occasional clears. Every
// response beat is checked against an in-bench model of the table, or against
// the fixed outcome of its directed row. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import pktu_pkg::*;

   localparam int MAX_PEERS  = 8;
   localparam int RAND_ITEMS = 1530;
   localparam int POOL_N     = 12;
   localparam int WATCHDOG   = 4000;
   localparam int DRAIN      = 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [STAMP_W-1:0]  stamp;
      logic [COUNT_W-1:0]  count;
   } outcome_type;

   typedef struct packed {
      logic          op;
      logic [KEY_W-1:0] key;
      logic          typed;
      outcome_type   want;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = OP_CLEAR;
   logic [63:0]        req_key_word0 = '0;
   logic [63:0]        req_key_word1 = '0;
   logic [63:0]        req_key_word2 = '0;
   logic [63:0]        req_key_word3 = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [STAMP_W-1:0] rsp_stamp;
   logic [COUNT_W-1:0] rsp_entry_count;

   // bench copy of the table
   logic [KEY_W-1:0]   peer_keys [MAX_PEERS];
   logic [STAMP_W-1:0] first_seen [MAX_PEERS];
   logic [STAMP_W-1:0] last_seen [MAX_PEERS];
   int unsigned        used_count;
   logic [STAMP_W-1:0] seq_next;

   outcome_type        pending_outcomes [$];
   dir_row_type        dir_rows [$];
   logic [KEY_W-1:0]   key_pool [POOL_N];

   bit                 calm = 1'b0;
   int                 mismatches = 0;
   int                 checked = 0;
   int                 idle_cycles = 0;
   int                 n_insert = 0, n_refresh = 0, n_reject = 0, n_clear = 0;

   peer_key_table_upsert #(.MAX_PEERS(MAX_PEERS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key_word0   (req_key_word0),
      .req_key_word1   (req_key_word1),
      .req_key_word2   (req_key_word2),
      .req_key_word3   (req_key_word3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_stamp       (rsp_stamp),
      .rsp_entry_count (rsp_entry_count)
   );

   always #5 clock = ~clock;

   function automatic void clear_peers();
      for (int i = 0; i < MAX_PEERS; i++) begin
         peer_keys[i]  = '0;
         first_seen[i] = '0;
         last_seen[i]  = '0;
      end
      used_count = 0;
      seq_next   = STAMP_FIRST;
   endfunction

   function automatic logic [STAMP_W-1:0] take_stamp();
      logic [STAMP_W-1:0] s;
      s = seq_next;
      seq_next = (seq_next == STAMP_LAST) ? STAMP_FIRST : seq_next + 1'b1;
      return s;
   endfunction

   function automatic outcome_type upsert_outcome(input logic op,
                                                  input logic [KEY_W-1:0] key);
      outcome_type o;
      int          hit;
      o   = '{STATUS_CLEARED, '0, '0, '0};
      hit = -1;
      if (op == OP_CLEAR) begin
         clear_peers();
      end else begin
         for (int i = 0; i < used_count; i++) begin
            if (hit < 0 && peer_keys[i] == key) hit = i;
         end
         if (hit >= 0) begin
            o.stamp = take_stamp();
            last_seen[hit] = o.stamp;
            o.slot   = hit[SLOT_W-1:0];
            o.status = STATUS_REFRESHED;
         end else if (used_count >= MAX_PEERS) begin
            o.status = STATUS_REJECTED;
         end else begin
            peer_keys[used_count]  = key;
            o.stamp                = take_stamp();
            first_seen[used_count] = o.stamp;
            last_seen[used_count]  = o.stamp;
            o.slot                 = used_count[SLOT_W-1:0];
            o.status               = STATUS_INSERTED;
            used_count++;
         end
      end
      o.count = used_count[COUNT_W-1:0];
      return o;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      return {rand_word(), rand_word(), rand_word(), rand_word()};
   endfunction

   function automatic dir_row_type dir_row(input logic op, input logic [KEY_W-1:0] key,
                                           input logic [STATUS_W-1:0] st,
                                           input int sl, input int stp, input int cnt);
      dir_row_type d;
      d.op    = op;
      d.key   = key;
      d.typed = 1'b1;
      d.want  = '{st, sl[SLOT_W-1:0], stp[STAMP_W-1:0], cnt[COUNT_W-1:0]};
      return d;
   endfunction

   // row checked against the bench model
   function automatic dir_row_type dir_pred(input logic op, input logic [KEY_W-1:0] key);
      dir_row_type d;
      d.op    = op;
      d.key   = key;
      d.typed = 1'b0;
      d.want  = '0;
      return d;
   endfunction

   task automatic send_beat(input logic op, input logic [KEY_W-1:0] key,
                            input logic typed, input outcome_type want);
      outcome_type o;
      int          gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_word0 <= key[63:0];
      req_key_word1 <= key[127:64];
      req_key_word2 <= key[191:128];
      req_key_word3 <= key[255:192];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      o = upsert_outcome(op, key);
      if (typed) o = want;
      pending_outcomes.push_back(o);
      case (o.status)
         STATUS_INSERTED:  n_insert++;
         STATUS_REFRESHED: n_refresh++;
         STATUS_REJECTED:  n_reject++;
         default:          n_clear++;
      endcase
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side back-pressure
   initial begin
      int n;
      forever begin
         n = idle_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_slot, rsp_stamp, rsp_entry_count};
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: status %0d slot %0d stamp %h count %0d",
                        got.status, got.slot, got.stamp, got.count);
         end else begin
            want = pending_outcomes.pop_front();
            checked++;
            if (got.status !== want.status || got.slot !== want.slot ||
                got.stamp !== want.stamp || got.count !== want.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch beat %0d: want st %0d slot %0d stamp %h cnt %0d,",
                            " got st %0d slot %0d stamp %h cnt %0d"},
                           checked, want.status, want.slot, want.stamp, want.count,
                           got.status, got.slot, got.stamp, got.count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("timeout: no beat for %0d cycles, %0d responses outstanding",
                  idle_cycles, pending_outcomes.size());
         $display("peer_key_table_upsert verification failed");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] kz, ko, k55, kaa, key;
      int               r, b;
      logic             op;
      kz  = '0;
      ko  = '1;
      k55 = {4{64'h5555_5555_5555_5555}};
      kaa = {4{64'hAAAA_AAAA_AAAA_AAAA}};
      clear_peers();

      dir_rows.push_back(dir_row(OP_UPSERT, kz, STATUS_INSERTED, 0, 1, 1));
      dir_rows.push_back(dir_row(OP_UPSERT, ko, STATUS_INSERTED, 1, 2, 2));
      dir_rows.push_back(dir_pred(OP_UPSERT, kz));
      // one bit off the all-ones key, in each word
      dir_rows.push_back(dir_pred(OP_UPSERT, ko ^ (256'd1 << 192)));
      dir_rows.push_back(dir_pred(OP_UPSERT, ko ^ (256'd1 << 191)));
      dir_rows.push_back(dir_pred(OP_UPSERT, ko ^ (256'd1 << 64)));
      dir_rows.push_back(dir_pred(OP_UPSERT, ko ^ (256'd1 << 63)));
      dir_rows.push_back(dir_pred(OP_UPSERT, kaa));
      dir_rows.push_back(dir_pred(OP_UPSERT, k55));
      // full
      dir_rows.push_back(dir_row(OP_UPSERT, 256'd1, STATUS_REJECTED, 0, 0, 8));
      dir_rows.push_back(dir_pred(OP_UPSERT, ko));
      dir_rows.push_back(dir_pred(OP_UPSERT, k55));
      dir_rows.push_back(dir_row(OP_UPSERT, ko ^ (256'd1 << 255), STATUS_REJECTED, 0, 0, 8));
      dir_rows.push_back(dir_row(OP_CLEAR, ko, STATUS_CLEARED, 0, 0, 0));
      dir_rows.push_back(dir_row(OP_CLEAR, kz, STATUS_CLEARED, 0, 0, 0));
      dir_rows.push_back(dir_row(OP_UPSERT, k55, STATUS_INSERTED, 0, 1, 1));
      dir_rows.push_back(dir_pred(OP_UPSERT, k55));
      dir_rows.push_back(dir_pred(OP_UPSERT, ko));
      dir_rows.push_back(dir_row(OP_CLEAR, k55, STATUS_CLEARED, 0, 0, 0));
      dir_rows.push_back(dir_row(OP_UPSERT, ko, STATUS_INSERTED, 0, 1, 1));

      for (int i = 0; i < POOL_N; i++) key_pool[i] = rand_key();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_beat(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed,
                                      dir_rows[i].want);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if ($urandom_range(0, 149) == 0) calm = ~calm;
         r  = $urandom_range(0, 99);
         op = OP_UPSERT;
         if (r < 4) begin
            op  = OP_CLEAR;
            key = rand_key();
            if ($urandom_range(0, 2) == 0)
               for (int j = 0; j < POOL_N; j++) key_pool[j] = rand_key();
         end else if (r < 72) begin
            key = key_pool[$urandom_range(0, POOL_N - 1)];
         end else if (r < 84) begin
            key    = key_pool[$urandom_range(0, POOL_N - 1)];
            b      = $urandom_range(0, KEY_W - 1);
            key[b] = ~key[b];
         end else begin
            key = rand_key();
         end
         send_beat(op, key, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("requests: %0d inserts, %0d refreshes, %0d rejects, %0d clears",
               n_insert, n_refresh, n_reject, n_clear);
      $display("responses checked: %0d, mismatching or unexpected: %0d", checked, mismatches);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("peer_key_table_upsert verification clean");
      end else begin
         $display("peer_key_table_upsert verification failed");
      end
      $finish;
   end

endmodule
